FILE: rtl/core/ffl_pkg.sv
// Shared types and constants for the first-fit free list.
`default_nettype none
package ffl_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned TDATA_W = ((ADDR_W + SIZE_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_TAKE_ADDR = 2'd2,
    OP_TAKE_FIT  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ffl_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } ffl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/ffl_dp.sv
// Datapath of the free list: descriptor cells, parallel match, collapse and result register.
`default_nettype none
module ffl_dp import ffl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ffl_cmd_t          cmd_i,
  input  wire op_e               op_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [SIZE_W-1:0] size_i,
  output ffl_sts_t               sts_o,
  output status_e                status_o,
  output logic [ADDR_W-1:0]      out_addr_o,
  output logic [SIZE_W-1:0]      out_size_o
);

  logic [ADDR_W-1:0]  cell_addr_q [ENTRIES];
  logic [SIZE_W-1:0]  cell_size_q [ENTRIES];
  logic [CNT_W-1:0]   count_q;

  op_e                op_q;
  logic [ADDR_W-1:0]  req_addr_q;
  logic [SIZE_W-1:0]  req_size_q;
  logic [ENTRIES-1:0] first_q;
  logic               hit_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [ENTRIES-1:0] after;
  logic [ADDR_W-1:0]  sel_addr;
  logic [SIZE_W-1:0]  sel_size;
  logic               full;

  status_e            status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [SIZE_W-1:0]  out_size_q;

  // Every valid cell compares against the request at once.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = 1'b0;
      if (CNT_W'(i) < count_q) begin
        case (op_i)
          OP_POP:       match[i] = 1'b1;
          OP_TAKE_ADDR: match[i] = (cell_addr_q[i] == addr_i);
          OP_TAKE_FIT:  match[i] = (cell_size_q[i] >= size_i);
          default:      match[i] = 1'b0;
        endcase
      end
    end
  end

  // Lowest set bit is the entry nearest the front.
  assign first = match & (~match + 1'b1);

  // Cells at and behind the removed one take their successor.
  assign after = ~(first_q - 1'b1);
  assign full  = (count_q == CNT_W'(ENTRIES));

  always_comb begin
    sel_addr = '0;
    sel_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_addr = sel_addr | (cell_addr_q[i] & {ADDR_W{first_q[i]}});
      sel_size = sel_size | (cell_size_q[i] & {SIZE_W{first_q[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      req_addr_q <= addr_i;
      req_size_q <= size_i;
      first_q    <= first;
      hit_q      <= |match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      if (op_q == OP_PUSH) begin
        if (!full) begin
          count_q <= count_q + 1'b1;
        end
      end else if (hit_q) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == OP_PUSH) begin
        if (!full) begin
          for (int i = 1; i < ENTRIES; i++) begin
            cell_addr_q[i] <= cell_addr_q[i-1];
            cell_size_q[i] <= cell_size_q[i-1];
          end
          cell_addr_q[0] <= req_addr_q;
          cell_size_q[0] <= req_size_q;
        end
      end else if (hit_q) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          if (after[i]) begin
            cell_addr_q[i] <= cell_addr_q[i+1];
            cell_size_q[i] <= cell_size_q[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == OP_PUSH) begin
        status_q   <= full ? ST_FULL : ST_OK;
        out_addr_q <= '0;
        out_size_q <= '0;
      end else if (hit_q) begin
        status_q   <= ST_OK;
        out_addr_q <= sel_addr;
        out_size_q <= sel_size;
      end else begin
        status_q   <= ST_NONE;
        out_addr_q <= '0;
        out_size_q <= '0;
      end
    end
  end

  assign sts_o.count = count_q;
  assign status_o    = status_q;
  assign out_addr_o  = out_addr_q;
  assign out_size_o  = out_size_q;

endmodule
`default_nettype wire

FILE: rtl/core/ffl_ctrl.sv
// Controller of the free list: request handshake, two-step sequencing and result valid.
`default_nettype none
module ffl_ctrl import ffl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  output ffl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign s_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture = s_valid_i && s_ready_o;
  // The collapse waits until the result register can take the new result.
  assign cmd_o.commit  = (state_q == S_EXEC) && (!out_valid_q || m_ready_i);
  assign m_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/first_fit_free_list_top.sv
// A request is captured into the request registers, and its result is registered once the output is free.
// Requests are taken only while idle: the compare over all cells runs as one is accepted, then the collapse.
// The result register lets the next request in while the previous result waits.
// Reset empties the list at once; the descriptor cells themselves are not cleared.
// Top level of the first-fit free list.
`default_nettype none
module first_fit_free_list_top import ffl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // block_addr[31:0], block_size[62:32], zero
  input  wire logic [OP_W-1:0]    s_axis_tuser,  // op[1:0]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,  // out_addr[31:0], out_size[62:32], zero
  output logic [ST_W-1:0]         m_axis_tuser   // status[1:0]
);

  ffl_cmd_t          cmd;
  ffl_sts_t          sts;
  status_e           status;
  logic [ADDR_W-1:0] out_addr;
  logic [SIZE_W-1:0] out_size;

  ffl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  ffl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (op_e'(s_axis_tuser)),
    .addr_i     (s_axis_tdata[ADDR_W-1:0]),
    .size_i     (s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
    .sts_o      (sts),
    .status_o   (status),
    .out_addr_o (out_addr),
    .out_size_o (out_size)
  );

  assign m_axis_tdata = {{(TDATA_W - ADDR_W - SIZE_W){1'b0}}, out_size, out_addr};
  assign m_axis_tuser = ST_W'(status);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CNT_W'(ENTRIES))
    else $error("free list holds more entries than cells");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> (status != ST_FULL || sts.count == CNT_W'(ENTRIES)))
    else $error("full status reported with a free cell");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != ST_OK) |-> (out_addr == '0 && out_size == '0))
    else $error("failed request returned a descriptor");

endmodule
`default_nettype wire
